[rtl/rcmm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmm_pkg: shared constants and helpers for the rectangle cut block
// memo geometry and the address function used by the fill sequencer and lookup
// ----------------------------------------------------------------------------
package rcmm_pkg;

  localparam int MaxSide   = 16;
  localparam int MaxCuts   = 16;
  localparam int MemoDepth = MaxSide * MaxSide * (MaxCuts + 1);
  localparam int AddrW     = $clog2(MemoDepth);
  localparam int EntryW    = 10;  // {impossible, area[8:0]}

  // w, h in 1..MaxSide, c in 0..MaxCuts
  function automatic logic [AddrW-1:0] memo_addr(logic [4:0] w, logic [4:0] h,
                                                 logic [4:0] c);
    logic [AddrW-1:0] row;
    row = AddrW'(w - 5'd1) * AddrW'(MaxSide) + AddrW'(h - 5'd1);
    return row * AddrW'(MaxCuts + 1) + AddrW'(c);
  endfunction

endpackage

[rtl/rcmm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmm_ram: generic single-write, single-read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module rcmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rect_cut_min_max_area_dp_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_cut_min_max_area_dp_top: guillotine cut min-max piece area
// answers queries from a memo of all sub-rectangle results
// ----------------------------------------------------------------------------
// After reset the block fills the whole memo (16 x 16 sides, 0..16 cuts) in
// dependency order with one shared max/compare step. Each cut position and
// cut split takes an issue state (a registered read of both sub-results from
// two ram copies) and then a compare state, and each entry adds its own entry
// and write states. in_ready_o stays low until the fill is done. After that an
// in-range item passes through accept, memo read and result register, and the
// next item is taken once the result has been delivered. Out-of-range fields
// give impossible_o = 1 in the cycle after accept.
module rect_cut_min_max_area_dp_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] width_i,
  input  logic [4:0] height_i,
  input  logic [4:0] pieces_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [8:0] min_max_area_o,
  output logic       impossible_o
);

  typedef enum logic [2:0] {
    S_ENTRY, S_ISSUE, S_EVAL, S_WRITE, S_IDLE, S_LOOK
  } state_e;

  state_e state_q;
  logic [4:0] w_q, h_q, c_q, pos_q, k_q;
  logic       dir_q;   // 0 vertical, 1 horizontal
  logic [8:0] best_q;
  logic       bad_q;
  logic       out_valid_q, imp_q;
  logic [8:0] area_q;

  logic [rcmm_pkg::AddrW-1:0]  addr_a, addr_b, raddr_a, waddr;
  logic [rcmm_pkg::EntryW-1:0] rdata_a, rdata_b, wdata;
  logic [4:0] a_w, a_h, b_w, b_h, kb;
  logic [9:0] area;
  logic       we, in_ok, last_k;
  logic [8:0] m;

  assign a_w = dir_q ? w_q : pos_q;
  assign a_h = dir_q ? pos_q : h_q;
  assign b_w = dir_q ? w_q : w_q - pos_q;
  assign b_h = dir_q ? h_q - pos_q : h_q;
  assign kb  = c_q - 5'd1 - k_q;
  assign addr_a = rcmm_pkg::memo_addr(a_w, a_h, k_q);
  assign addr_b = rcmm_pkg::memo_addr(b_w, b_h, kb);
  assign raddr_a = (state_q == S_IDLE) ?
                   rcmm_pkg::memo_addr(width_i, height_i, pieces_i - 5'd1) : addr_a;
  assign waddr = rcmm_pkg::memo_addr(w_q, h_q, c_q);
  assign wdata = {bad_q, bad_q ? 9'd0 : best_q};
  assign we    = (state_q == S_WRITE);
  assign area  = 10'(w_q) * 10'(h_q);
  assign last_k = (k_q == c_q - 5'd1);
  assign m = (rdata_a[8:0] > rdata_b[8:0]) ? rdata_a[8:0] : rdata_b[8:0];

  assign in_ok = (width_i != 5'd0) && (width_i <= 5'(rcmm_pkg::MaxSide)) &&
                 (height_i != 5'd0) && (height_i <= 5'(rcmm_pkg::MaxSide)) &&
                 (pieces_i != 5'd0) && (pieces_i <= 5'(rcmm_pkg::MaxCuts + 1));

  assign in_ready_o     = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign min_max_area_o = area_q;
  assign impossible_o   = imp_q;

  // two copies so both sub-results are read in the same cycle
  rcmm_ram #(.Width(rcmm_pkg::EntryW), .Depth(rcmm_pkg::MemoDepth)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_a), .rdata_o(rdata_a)
  );
  rcmm_ram #(.Width(rcmm_pkg::EntryW), .Depth(rcmm_pkg::MemoDepth)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(addr_b), .rdata_o(rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ENTRY;
      w_q         <= 5'd1;
      h_q         <= 5'd1;
      c_q         <= 5'd0;
      pos_q       <= 5'd1;
      k_q         <= 5'd0;
      dir_q       <= 1'b0;
      best_q      <= 9'd0;
      bad_q       <= 1'b1;
      out_valid_q <= 1'b0;
      imp_q       <= 1'b0;
      area_q      <= 9'd0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ENTRY: begin
          k_q <= 5'd0;
          pos_q <= 5'd1;
          dir_q <= (w_q == 5'd1);
          if (c_q == 5'd0) begin
            best_q <= area[8:0];
            bad_q  <= 1'b0;
            state_q <= S_WRITE;
          end else if (10'(c_q) + 10'd1 > area) begin
            bad_q  <= 1'b1;
            state_q <= S_WRITE;
          end else begin
            bad_q  <= 1'b1;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_EVAL;
        S_EVAL: begin
          if (!rdata_a[9] && !rdata_b[9] && (bad_q || m < best_q)) begin
            best_q <= m;
            bad_q  <= 1'b0;
          end
          state_q <= S_ISSUE;
          if (!last_k) begin
            k_q <= k_q + 5'd1;
          end else begin
            k_q <= 5'd0;
            if (!dir_q && pos_q != w_q - 5'd1) begin
              pos_q <= pos_q + 5'd1;
            end else if (!dir_q && h_q > 5'd1) begin
              dir_q <= 1'b1;
              pos_q <= 5'd1;
            end else if (dir_q && pos_q != h_q - 5'd1) begin
              pos_q <= pos_q + 5'd1;
            end else begin
              state_q <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          state_q <= S_ENTRY;
          if (c_q != 5'(rcmm_pkg::MaxCuts)) begin
            c_q <= c_q + 5'd1;
          end else begin
            c_q <= 5'd0;
            if (h_q != 5'(rcmm_pkg::MaxSide)) begin
              h_q <= h_q + 5'd1;
            end else begin
              h_q <= 5'd1;
              if (w_q != 5'(rcmm_pkg::MaxSide)) begin
                w_q <= w_q + 5'd1;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            if (in_ok) begin
              state_q <= S_LOOK;
            end else begin
              out_valid_q <= 1'b1;
              imp_q       <= 1'b1;
              area_q      <= 9'd0;
            end
          end
        end
        S_LOOK: begin
          out_valid_q <= 1'b1;
          imp_q       <= rdata_a[9];
          area_q      <= rdata_a[9] ? 9'd0 : rdata_a[8:0];
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no write may land once queries are being served
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_LOOK) |-> !we)
    else $error("memo written outside fill");

  // cut split stays below the cut count while comparing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (k_q < c_q))
    else $error("cut split out of range");

  // a lookup always produces a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |=> out_valid_q)
    else $error("lookup result lost");

  // impossible results always carry a zero area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && imp_q) |-> (area_q == 9'd0))
    else $error("impossible item with nonzero area");
`endif

endmodule

[tb/rect_cut_min_max_area_dp_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_cut_min_max_area_dp_top_tb: self-checking bench for guillotine min-max
// answers are predicted from a locally built table of every sub-rectangle
// result; directed corners, a drain pause and random items with stalls
// ----------------------------------------------------------------------------
module rect_cut_min_max_area_dp_top_tb;

  typedef struct packed {
    logic [8:0] area;
    logic       bad;
  } cut_answer_t;

  localparam int unsigned StallLimit = 24_000_000;  // must outlast the memo fill

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [4:0] width_i = '0;
  logic [4:0] height_i = '0;
  logic [4:0] pieces_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [8:0] min_max_area_o;
  logic       impossible_o;

  int unsigned best_area [1:rcmm_pkg::MaxSide][1:rcmm_pkg::MaxSide][0:rcmm_pkg::MaxCuts];
  bit          best_bad  [1:rcmm_pkg::MaxSide][1:rcmm_pkg::MaxSide][0:rcmm_pkg::MaxCuts];

  cut_answer_t answer_q[$];
  int unsigned n_sent, n_checked, n_errors, n_impossible, quiet_cycles;
  bit          idle_on = 1'b1;

  rect_cut_min_max_area_dp_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bottom-up: every sub-rectangle has a smaller side, so it is already filled
  task automatic build_answer_table();
    int unsigned a1, a2, m, bst;
    bit          bb, b1, b2;
    for (int w = 1; w <= rcmm_pkg::MaxSide; w++) begin
      for (int h = 1; h <= rcmm_pkg::MaxSide; h++) begin
        for (int c = 0; c <= rcmm_pkg::MaxCuts; c++) begin
          bst = 0;
          bb  = 1'b1;
          if (c == 0) begin
            bst = w * h;
            bb  = 1'b0;
          end else if (c + 1 <= w * h) begin
            for (int p = 1; p < w; p++) begin
              for (int k = 0; k < c; k++) begin
                a1 = best_area[p][h][k];     b1 = best_bad[p][h][k];
                a2 = best_area[w-p][h][c-1-k]; b2 = best_bad[w-p][h][c-1-k];
                if (!b1 && !b2) begin
                  m = (a1 > a2) ? a1 : a2;
                  if (bb || m < bst) begin
                    bst = m;
                    bb  = 1'b0;
                  end
                end
              end
            end
            for (int p = 1; p < h; p++) begin
              for (int k = 0; k < c; k++) begin
                a1 = best_area[w][p][k];     b1 = best_bad[w][p][k];
                a2 = best_area[w][h-p][c-1-k]; b2 = best_bad[w][h-p][c-1-k];
                if (!b1 && !b2) begin
                  m = (a1 > a2) ? a1 : a2;
                  if (bb || m < bst) begin
                    bst = m;
                    bb  = 1'b0;
                  end
                end
              end
            end
            if (bb) bst = 0;
          end
          best_area[w][h][c] = bst;
          best_bad[w][h][c]  = bb;
        end
      end
    end
  endtask

  function automatic cut_answer_t predict_cut(logic [4:0] w, logic [4:0] h, logic [4:0] p);
    cut_answer_t r;
    r.area = '0;
    r.bad  = 1'b1;
    if (w >= 1 && w <= rcmm_pkg::MaxSide && h >= 1 && h <= rcmm_pkg::MaxSide &&
        p >= 1 && p <= rcmm_pkg::MaxCuts + 1) begin
      r.bad = best_bad[w][h][p-1];
      if (!r.bad) r.area = 9'(best_area[w][h][p-1]);
    end
    return r;
  endfunction

  // valid stays high across back-to-back items; lowered only for a gap or a drain
  task automatic send_query(logic [4:0] w, logic [4:0] h, logic [4:0] p);
    if (idle_on && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    width_i    <= w;
    height_i   <= h;
    pieces_i   <= p;
    do @(posedge clk_i); while (!in_ready_o);
    answer_q.push_back(predict_cut(w, h, p));
    n_sent++;
  endtask

  task automatic wait_answers_drained();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corners();
    send_query(5'd1, 5'd1, 5'd1);
    send_query(5'd16, 5'd16, 5'd1);
    send_query(5'd16, 5'd16, 5'd17);
    send_query(5'd16, 5'd16, 5'd2);
    send_query(5'd1, 5'd1, 5'd2);    // more pieces than cells
    send_query(5'd16, 5'd1, 5'd17);  // more pieces than cells
    send_query(5'd16, 5'd1, 5'd16);
    send_query(5'd2, 5'd1, 5'd2);
    send_query(5'd4, 5'd4, 5'd16);
    send_query(5'd3, 5'd5, 5'd17);
    send_query(5'd7, 5'd3, 5'd5);
    send_query(5'd1, 5'd16, 5'd9);
    // fields out of range, then one in-range item
    send_query(5'd0, 5'd5, 5'd3);
    send_query(5'd5, 5'd0, 5'd3);
    send_query(5'd5, 5'd5, 5'd0);
    send_query(5'd17, 5'd4, 5'd2);
    send_query(5'd4, 5'd17, 5'd2);
    send_query(5'd4, 5'd4, 5'd18);
    send_query(5'd31, 5'd31, 5'd31);
    send_query(5'd15, 5'd14, 5'd13);
  endtask

  task automatic test_drain_pause();
    wait_answers_drained();
    repeat (5) @(posedge clk_i);
    send_query(5'd9, 5'd11, 5'd6);
    send_query(5'd10, 5'd10, 5'd17);
  endtask

  task automatic test_random_queries();
    logic [4:0] w, h, p;
    for (int i = 0; i < 80; i++) begin
      idle_on = !(i >= 30 && i < 55);  // burst with no idling on either side
      if ($urandom_range(0, 9) < 8) begin
        w = 5'($urandom_range(1, rcmm_pkg::MaxSide));
        h = 5'($urandom_range(1, rcmm_pkg::MaxSide));
        p = 5'($urandom_range(1, rcmm_pkg::MaxCuts + 1));
      end else begin
        w = 5'($urandom);
        h = 5'($urandom);
        p = 5'($urandom);
      end
      send_query(w, h, p);
    end
    idle_on = 1'b1;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    cut_answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $error("result with no query outstanding: area=%0d impossible=%0b",
               min_max_area_o, impossible_o);
        n_errors++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (min_max_area_o !== exp_ans.area) begin
          $error("min_max_area: expected %0d, got %0d", exp_ans.area, min_max_area_o);
          n_errors++;
        end
        if (impossible_o !== exp_ans.bad) begin
          $error("impossible: expected %0b, got %0b", exp_ans.bad, impossible_o);
          n_errors++;
        end
        if (exp_ans.bad) n_impossible++;
        n_checked++;
      end
    end
    out_ready_i <= !(idle_on && $urandom_range(0, 99) < 18);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no item moved in %0d cycles", StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    build_answer_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corners();
    test_drain_pause();
    test_random_queries();
    wait_answers_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d and checked %0d queries (%0d impossible or out of range),",
             n_sent, n_checked, n_impossible);
    $display("field corners, a full drain pause, random stalls and a no-stall burst");
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[rect_cut_min_max_area_dp_top.f]
rtl/rcmm_pkg.sv
rtl/rcmm_ram.sv
rtl/rect_cut_min_max_area_dp_top.sv
tb/rect_cut_min_max_area_dp_top_tb.sv
